// ----- sv/lesp_pkg.sv -----
// lesp_pkg: shared types and constants for the look elevator stop scheduler
// used by lesp_stop_store, lesp_sub_unit, lesp_sched_ctrl and the top level
`default_nettype none

package lesp_pkg;

    localparam int FLOOR_W     = 6;
    localparam int TOTAL_W     = 7;
    localparam int FLOOR_COUNT = 64;
    localparam int STORE_DEPTH = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_EXEC = 1'b1;

    typedef struct packed {
        logic wr;
        logic serve;
        logic clr;
    } t_store_cmd;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PICK  = 4'b0100,
        S_EMPTY = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- sv/look_elevator_stop_scheduler_unit.sv -----
// look_elevator_stop_scheduler_unit: single-car LOOK stop scheduler, top level
// depends on lesp_pkg, lesp_stop_store, lesp_sub_unit and lesp_sched_ctrl
//
//   channel  handshake           payload
//   in       i_valid / o_ready   i_func, i_floor
//   out      o_valid / i_ready   o_stop_floor, o_seek_total, o_last, o_no_stops, o_dropped
//
// an add word is taken while idle and leaves the unit idle; an empty execute goes through the empty state only
// an execute with stops serves each one by a full scan of a store through the shared
// subtractor and then a pick state, plus one more full scan to turn around when both
// stores hold stops
// o_ready is high only while idle; a full output register holds the pick or empty state
// reset is synchronous, active low; stores need no clearing pass
`default_nettype none

module look_elevator_stop_scheduler_unit #(
    parameter int STORE_DEPTH = lesp_pkg::STORE_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_func,
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_floor,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [lesp_pkg::FLOOR_W-1:0] o_stop_floor,
    output logic [lesp_pkg::TOTAL_W-1:0] o_seek_total,
    output logic                         o_last,
    output logic                         o_no_stops,
    output logic                         o_dropped
);

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    lesp_pkg::t_store_cmd         w_up_cmd, w_dn_cmd;
    logic [IDX_W-1:0]             w_serve_idx, w_rd_idx;
    logic [lesp_pkg::FLOOR_W-1:0] w_up_data, w_dn_data;
    logic                         w_up_pend, w_dn_pend;
    logic [CNT_W-1:0]             w_up_count, w_dn_count;
    logic                         w_up_full, w_dn_full;

    lesp_stop_store #(
        .DEPTH (STORE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_up_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_up_cmd),
        .i_wr_data   (i_floor),
        .i_serve_idx (w_serve_idx),
        .i_rd_idx    (w_rd_idx),
        .o_rd_data   (w_up_data),
        .o_rd_pend   (w_up_pend),
        .o_count     (w_up_count),
        .o_full      (w_up_full)
    );

    lesp_stop_store #(
        .DEPTH (STORE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_dn_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_dn_cmd),
        .i_wr_data   (i_floor),
        .i_serve_idx (w_serve_idx),
        .i_rd_idx    (w_rd_idx),
        .o_rd_data   (w_dn_data),
        .o_rd_pend   (w_dn_pend),
        .o_count     (w_dn_count),
        .o_full      (w_dn_full)
    );

    lesp_sched_ctrl #(
        .DEPTH (STORE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_floor      (i_floor),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_stop_floor (o_stop_floor),
        .o_seek_total (o_seek_total),
        .o_last       (o_last),
        .o_no_stops   (o_no_stops),
        .o_dropped    (o_dropped),
        .o_up_cmd     (w_up_cmd),
        .o_dn_cmd     (w_dn_cmd),
        .o_serve_idx  (w_serve_idx),
        .o_rd_idx     (w_rd_idx),
        .i_up_data    (w_up_data),
        .i_up_pend    (w_up_pend),
        .i_up_count   (w_up_count),
        .i_up_full    (w_up_full),
        .i_dn_data    (w_dn_data),
        .i_dn_pend    (w_dn_pend),
        .i_dn_count   (w_dn_count),
        .i_dn_full    (w_dn_full)
    );

endmodule

`default_nettype wire

// ----- sv/lesp_stop_store.sv -----
// lesp_stop_store: one request store (up or down) with fill count and pending bits
// depends on lesp_pkg for t_store_cmd and the floor width
// read data is registered, so i_rd_idx carries the next scan address
`default_nettype none

module lesp_stop_store #(
    parameter int DEPTH = lesp_pkg::STORE_DEPTH,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  lesp_pkg::t_store_cmd         i_cmd,
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_wr_data,
    input  wire  [IDX_W-1:0]             i_serve_idx,
    input  wire  [IDX_W-1:0]             i_rd_idx,
    output logic [lesp_pkg::FLOOR_W-1:0] o_rd_data,
    output logic                         o_rd_pend,
    output logic [CNT_W-1:0]             o_count,
    output logic                         o_full
);

    logic [lesp_pkg::FLOOR_W-1:0] r_mem [DEPTH];
    logic [lesp_pkg::FLOOR_W-1:0] r_rd_data;
    logic [IDX_W-1:0]             r_rd_idx;
    logic [DEPTH-1:0]             r_pend;
    logic [CNT_W-1:0]             r_count;
    logic                         w_wr;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign w_wr      = i_cmd.wr && !o_full;
    assign o_count   = r_count;
    assign o_rd_data = r_rd_data;
    assign o_rd_pend = r_pend[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (w_wr && !i_cmd.clr) begin
            r_mem[r_count[IDX_W-1:0]] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
        r_rd_idx  <= i_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= '0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
            r_pend  <= '0;
        end else begin
            if (w_wr) begin
                r_count                    <= r_count + CNT_W'(1);
                r_pend[r_count[IDX_W-1:0]] <= 1'b1;
            end
            if (i_cmd.serve) begin
                r_pend[i_serve_idx] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/lesp_sub_unit.sv -----
// lesp_sub_unit: shared floor subtractor, gives a < b and |a - b|
// depends on lesp_pkg for the floor width
`default_nettype none

module lesp_sub_unit (
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_a,
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_b,
    output logic                         o_lt,
    output logic [lesp_pkg::FLOOR_W-1:0] o_abs
);

    logic [lesp_pkg::FLOOR_W:0] w_diff;

    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_lt   = w_diff[lesp_pkg::FLOOR_W];
    assign o_abs  = o_lt ? (i_b - i_a) : w_diff[lesp_pkg::FLOOR_W-1:0];

endmodule

`default_nettype wire

// ----- sv/lesp_sched_ctrl.sv -----
// lesp_sched_ctrl: sequencer that files requests and serves stops by repeated scans
// depends on lesp_pkg and lesp_sub_unit; drives the two lesp_stop_store instances
`default_nettype none

module lesp_sched_ctrl #(
    parameter int DEPTH = lesp_pkg::STORE_DEPTH,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_func,
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_floor,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [lesp_pkg::FLOOR_W-1:0] o_stop_floor,
    output logic [lesp_pkg::TOTAL_W-1:0] o_seek_total,
    output logic                         o_last,
    output logic                         o_no_stops,
    output logic                         o_dropped,
    output lesp_pkg::t_store_cmd         o_up_cmd,
    output lesp_pkg::t_store_cmd         o_dn_cmd,
    output logic [IDX_W-1:0]             o_serve_idx,
    output logic [IDX_W-1:0]             o_rd_idx,
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_up_data,
    input  wire                          i_up_pend,
    input  wire  [CNT_W-1:0]             i_up_count,
    input  wire                          i_up_full,
    input  wire  [lesp_pkg::FLOOR_W-1:0] i_dn_data,
    input  wire                          i_dn_pend,
    input  wire  [CNT_W-1:0]             i_dn_count,
    input  wire                          i_dn_full
);

    localparam int LEFT_W = $clog2(2 * DEPTH + 1);
    localparam int FW     = lesp_pkg::FLOOR_W;
    localparam int TW     = lesp_pkg::TOTAL_W;

    lesp_pkg::t_state r_state, n_state;

    logic              r_dir_up, n_dir_up;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [FW-1:0]     r_best, n_best;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [FW-1:0]     r_car, n_car;
    logic [TW-1:0]     r_total, n_total;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_drop, n_drop;
    logic              r_ovf, n_ovf;

    logic              r_o_valid, n_o_valid;
    logic [FW-1:0]     r_o_stop, n_o_stop;
    logic [TW-1:0]     r_o_total, n_o_total;
    logic              r_o_last, n_o_last;
    logic              r_o_none, n_o_none;
    logic              r_o_drop, n_o_drop;

    logic              w_accept;
    logic              w_slot_free;
    logic [FW-1:0]     w_cand;
    logic              w_pend;
    logic [FW-1:0]     w_alu_a, w_alu_b;
    logic              w_alu_lt;
    logic [FW-1:0]     w_alu_abs;
    logic [TW:0]       w_sum;
    logic [TW-1:0]     w_sat;
    logic              w_in_range;
    logic              w_go_up;

    lesp_sub_unit u_sub (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_lt  (w_alu_lt),
        .o_abs (w_alu_abs)
    );

    assign o_ready      = (r_state == lesp_pkg::S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_slot_free  = !r_o_valid || i_ready;
    assign w_cand       = r_dir_up ? i_up_data : i_dn_data;
    assign w_pend       = r_dir_up ? i_up_pend : i_dn_pend;
    assign w_in_range   = ({1'b0, 8'(i_floor)} < 9'(lesp_pkg::FLOOR_COUNT));
    assign w_go_up      = (i_floor > r_car);
    assign w_sum        = {1'b0, r_total} + (TW + 1)'(w_alu_abs);
    assign w_sat        = (w_sum > (TW + 1)'(lesp_pkg::TOTAL_MAX)) ?
                          lesp_pkg::TOTAL_MAX : w_sum[TW-1:0];
    assign o_rd_idx     = n_idx;
    assign o_serve_idx  = r_best_idx;

    assign o_valid      = r_o_valid;
    assign o_stop_floor = r_o_stop;
    assign o_seek_total = r_o_total;
    assign o_last       = r_o_last;
    assign o_no_stops   = r_o_none;
    assign o_dropped    = r_o_drop;

    // one subtractor: candidate compare while scanning, travel distance when picking
    always_comb begin
        if (r_state == lesp_pkg::S_PICK) begin
            w_alu_a = r_best;
            w_alu_b = r_car;
        end else if (r_dir_up) begin
            w_alu_a = w_cand;
            w_alu_b = r_best;
        end else begin
            w_alu_a = r_best;
            w_alu_b = w_cand;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dir_up   = r_dir_up;
        n_idx      = r_idx;
        n_found    = r_found;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_car      = r_car;
        n_total    = r_total;
        n_left     = r_left;
        n_drop     = r_drop;
        n_ovf      = r_ovf;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_stop   = r_o_stop;
        n_o_total  = r_o_total;
        n_o_last   = r_o_last;
        n_o_none   = r_o_none;
        n_o_drop   = r_o_drop;
        o_up_cmd   = '0;
        o_dn_cmd   = '0;

        case (r_state)
            lesp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_func == lesp_pkg::FUNC_ADD) begin
                        if (w_in_range) begin
                            if (w_go_up) begin
                                if (i_up_full) n_ovf = 1'b1;
                                else o_up_cmd.wr = 1'b1;
                            end else begin
                                if (i_dn_full) n_ovf = 1'b1;
                                else o_dn_cmd.wr = 1'b1;
                            end
                        end
                    end else begin
                        n_drop   = r_ovf;
                        n_ovf    = 1'b0;
                        n_left   = LEFT_W'(i_up_count) + LEFT_W'(i_dn_count);
                        n_total  = '0;
                        n_dir_up = (i_up_count != '0);
                        n_idx    = '0;
                        n_found  = 1'b0;
                        if ((i_up_count == '0) && (i_dn_count == '0)) begin
                            n_state = lesp_pkg::S_EMPTY;
                        end else begin
                            n_state = lesp_pkg::S_SCAN;
                        end
                    end
                end
            end

            lesp_pkg::S_SCAN: begin
                if (w_pend && (!r_found || w_alu_lt)) begin
                    n_best     = w_cand;
                    n_best_idx = r_idx;
                    n_found    = 1'b1;
                end
                if (r_idx == IDX_W'(DEPTH - 1)) begin
                    n_state = lesp_pkg::S_PICK;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            lesp_pkg::S_PICK: begin
                if (!r_found) begin
                    // up side exhausted, turn around
                    n_dir_up = 1'b0;
                    n_idx    = '0;
                    n_state  = lesp_pkg::S_SCAN;
                end else if (w_slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_stop  = r_best;
                    n_o_total = w_sat;
                    n_o_last  = (r_left == LEFT_W'(1));
                    n_o_none  = 1'b0;
                    n_o_drop  = r_drop;
                    n_car     = r_best;
                    n_total   = w_sat;
                    n_left    = r_left - LEFT_W'(1);
                    n_found   = 1'b0;
                    n_idx     = '0;
                    if (r_dir_up) o_up_cmd.serve = 1'b1;
                    else o_dn_cmd.serve = 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        o_up_cmd.clr = 1'b1;
                        o_dn_cmd.clr = 1'b1;
                        n_state      = lesp_pkg::S_IDLE;
                    end else begin
                        n_state = lesp_pkg::S_SCAN;
                    end
                end
            end

            lesp_pkg::S_EMPTY: begin
                if (w_slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_stop  = r_car;
                    n_o_total = '0;
                    n_o_last  = 1'b1;
                    n_o_none  = 1'b1;
                    n_o_drop  = r_drop;
                    n_state   = lesp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lesp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lesp_pkg::S_IDLE;
            r_car     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
            r_found   <= 1'b0;
            r_dir_up  <= 1'b1;
            r_idx     <= '0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_car     <= n_car;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
            r_found   <= n_found;
            r_dir_up  <= n_dir_up;
            r_idx     <= n_idx;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_total    <= n_total;
        r_drop     <= n_drop;
        r_o_stop   <= n_o_stop;
        r_o_total  <= n_o_total;
        r_o_last   <= n_o_last;
        r_o_none   <= n_o_none;
        r_o_drop   <= n_o_drop;
    end

endmodule

`default_nettype wire
